### hw/rtl/usbf_pkg.sv
// Shared definitions for the serial data register block: default ring depth
// and the request action codes. No dependencies.
package usbf_pkg;

   localparam int DEPTH_DEFAULT = 16;

   typedef enum logic [1:0] {
      ACT_CPU_WRITE = 2'd0,
      ACT_CPU_READ  = 2'd1,
      ACT_LINE_RX   = 2'd2,
      ACT_LINE_TX   = 2'd3
   } action_type;

endpackage

### hw/rtl/uart_sbuf_dual_fifo.sv
// Serial data register with a transmit ring and a receive ring; uses usbf_pkg.
// A request accepted at one edge has its registered response on the rsp_ ports
// in the next cycle, marked by rsp_valid for exactly that cycle.
// Throughput: one request per cycle; busy is tied low, each request is one
// ring access and a pointer step at most. The receiver cannot stall.
// Reset (sync, active high) empties both rings, clears flags and rx_enable.
module uart_sbuf_dual_fifo #(
   parameter int DEPTH = usbf_pkg::DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_action,
   input  logic [7:0] req_data_in,
   // response channel
   output logic       rsp_valid,
   output logic [7:0] rsp_data_out,
   output logic       rsp_data_valid,
   output logic       rsp_rx_flag,
   output logic       rsp_tx_busy,
   output logic       rsp_dropped,
   // configuration: rx_enable
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);
   import usbf_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(DEPTH - 1);

   // ring pointers; a ring keeps one slot free, so equal pointers mean empty
   logic [PTR_W-1:0] tx_wp_ff, tx_wp_in, tx_rp_ff, tx_rp_in;
   logic [PTR_W-1:0] rx_wp_ff, rx_wp_in, rx_rp_ff, rx_rp_in;
   logic             rx_done_ff, rx_done_in;
   logic             tx_mark_ff, tx_mark_in;
   logic             rx_en_ff;

   // ring storage, written and read through clocked ports
   logic [7:0]       tx_mem [DEPTH];
   logic [7:0]       rx_mem [DEPTH];
   logic [7:0]       tx_rd_ff, rx_rd_ff;

   // response register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       echo_ff, echo_in;
   logic             pop_rx_ff, pop_rx_in;
   logic             pop_tx_ff, pop_tx_in;
   logic             dval_ff, dval_in;
   logic             drop_ff, drop_in;

   logic             accept;
   logic             tx_we, rx_we;
   logic [PTR_W-1:0] tx_wp_next, tx_rp_next, rx_wp_next, rx_rp_next;
   logic             tx_full, tx_empty, rx_full, rx_empty;

   function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
      return (p == LAST_POS) ? '0 : p + PTR_W'(1);
   endfunction

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   assign tx_wp_next = next_pos(tx_wp_ff);
   assign tx_rp_next = next_pos(tx_rp_ff);
   assign rx_wp_next = next_pos(rx_wp_ff);
   assign rx_rp_next = next_pos(rx_rp_ff);
   assign tx_full    = (tx_wp_next == tx_rp_ff);
   assign rx_full    = (rx_wp_next == rx_rp_ff);
   assign tx_empty   = (tx_wp_ff == tx_rp_ff);
   assign rx_empty   = (rx_wp_ff == rx_rp_ff);

   // per-request decode: pointer steps, flag updates, response fields
   always_comb begin
      tx_wp_in     = tx_wp_ff;
      tx_rp_in     = tx_rp_ff;
      rx_wp_in     = rx_wp_ff;
      rx_rp_in     = rx_rp_ff;
      rx_done_in   = rx_done_ff;
      tx_mark_in   = tx_mark_ff;
      tx_we        = 1'b0;
      rx_we        = 1'b0;
      rsp_valid_in = accept;
      echo_in      = '0;
      pop_rx_in    = 1'b0;
      pop_tx_in    = 1'b0;
      dval_in      = 1'b0;
      drop_in      = 1'b0;
      if (accept) begin
         unique case (action_type'(req_action))
            ACT_CPU_WRITE: begin
               // echoed even when the ring is full
               tx_mark_in = 1'b1;
               echo_in    = req_data_in;
               dval_in    = 1'b1;
               drop_in    = tx_full;
               if (!tx_full) begin
                  tx_we    = 1'b1;
                  tx_wp_in = tx_wp_next;
               end
            end
            ACT_CPU_READ: begin
               if (!rx_empty) begin
                  pop_rx_in = 1'b1;
                  dval_in   = 1'b1;
                  rx_rp_in  = rx_rp_next;
               end
            end
            ACT_LINE_RX: begin
               // flag is set even when the byte is lost
               if (rx_en_ff) begin
                  rx_done_in = 1'b1;
                  drop_in    = rx_full;
                  if (!rx_full) begin
                     rx_we    = 1'b1;
                     rx_wp_in = rx_wp_next;
                  end
               end
            end
            ACT_LINE_TX: begin
               if (!tx_empty) begin
                  pop_tx_in = 1'b1;
                  dval_in   = 1'b1;
                  tx_rp_in  = tx_rp_next;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         tx_wp_ff     <= '0;
         tx_rp_ff     <= '0;
         rx_wp_ff     <= '0;
         rx_rp_ff     <= '0;
         rx_done_ff   <= 1'b0;
         tx_mark_ff   <= 1'b0;
         rx_en_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tx_wp_ff     <= tx_wp_in;
         tx_rp_ff     <= tx_rp_in;
         rx_wp_ff     <= rx_wp_in;
         rx_rp_ff     <= rx_rp_in;
         rx_done_ff   <= rx_done_in;
         tx_mark_ff   <= tx_mark_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            rx_en_ff <= csr_wr_data;
         end
      end
   end

   // response payload, no reset needed
   always_ff @(posedge clock) begin
      echo_ff   <= echo_in;
      pop_rx_ff <= pop_rx_in;
      pop_tx_ff <= pop_tx_in;
      dval_ff   <= dval_in;
      drop_ff   <= drop_in;
   end

   // rings: head entry is read every cycle, so a pop finds its byte registered
   always_ff @(posedge clock) begin
      if (tx_we) begin
         tx_mem[tx_wp_ff] <= req_data_in;
      end
      tx_rd_ff <= tx_mem[tx_rp_ff];
   end

   always_ff @(posedge clock) begin
      if (rx_we) begin
         rx_mem[rx_wp_ff] <= req_data_in;
      end
      rx_rd_ff <= rx_mem[rx_rp_ff];
   end

   // flags are the state after the request; they move with rsp_valid
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data_out   = pop_rx_ff ? rx_rd_ff : (pop_tx_ff ? tx_rd_ff : echo_ff);
   assign rsp_data_valid = dval_ff;
   assign rsp_rx_flag    = rx_done_ff;
   assign rsp_tx_busy    = tx_mark_ff;
   assign rsp_dropped    = drop_ff;

endmodule

### test/uart_sbuf_dual_fifo_checker.sv
`timescale 1ns / 1ps
// Scoreboard for uart_sbuf_dual_fifo: watches the request, response and csr
// ports, keeps its own copy of both rings and compares every response.
// Depends on usbf_pkg.
module uart_sbuf_dual_fifo_checker #(
   parameter int DEPTH = usbf_pkg::DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       busy,
   input  logic [1:0] req_action,
   input  logic [7:0] req_data_in,
   input  logic       rsp_valid,
   input  logic [7:0] rsp_data_out,
   input  logic       rsp_data_valid,
   input  logic       rsp_rx_flag,
   input  logic       rsp_tx_busy,
   input  logic       rsp_dropped,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   output int         fail_count,
   output int         pending
);
   import usbf_pkg::*;

   typedef struct packed {
      logic [7:0] data_out;
      logic       data_valid;
      logic       rx_flag;
      logic       tx_busy;
      logic       dropped;
   } sbuf_rsp_type;

   logic [7:0]   tx_ring [DEPTH];
   logic [7:0]   rx_ring [DEPTH];
   int unsigned  tx_wr, tx_rd, rx_wr, rx_rd;
   logic         rx_done_m, tx_mark_m, rx_en_m;
   sbuf_rsp_type sbuf_rsp_q [$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   function automatic int unsigned ring_next(int unsigned p);
      return (p + 1 >= DEPTH) ? 0 : p + 1;
   endfunction

   // Applies one request to the model rings and returns its response.
   function automatic sbuf_rsp_type predict_sbuf(action_type act, logic [7:0] din);
      sbuf_rsp_type r;
      r = '0;
      case (act)
         ACT_CPU_WRITE: begin
            if (ring_next(tx_wr) == tx_rd) begin
               r.dropped = 1'b1;
            end else begin
               tx_ring[tx_wr] = din;
               tx_wr = ring_next(tx_wr);
            end
            tx_mark_m    = 1'b1;
            r.data_out   = din;
            r.data_valid = 1'b1;
         end
         ACT_CPU_READ: begin
            if (rx_wr != rx_rd) begin
               r.data_out   = rx_ring[rx_rd];
               r.data_valid = 1'b1;
               rx_rd = ring_next(rx_rd);
            end
         end
         ACT_LINE_RX: begin
            if (rx_en_m) begin
               if (ring_next(rx_wr) == rx_rd) begin
                  r.dropped = 1'b1;
               end else begin
                  rx_ring[rx_wr] = din;
                  rx_wr = ring_next(rx_wr);
               end
               rx_done_m = 1'b1;
            end
         end
         default: begin
            if (tx_wr != tx_rd) begin
               r.data_out   = tx_ring[tx_rd];
               r.data_valid = 1'b1;
               tx_rd = ring_next(tx_rd);
            end
         end
      endcase
      r.rx_flag = rx_done_m;
      r.tx_busy = tx_mark_m;
      return r;
   endfunction

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      sbuf_rsp_type got, want;
      if (reset) begin
         tx_wr = 0;
         tx_rd = 0;
         rx_wr = 0;
         rx_rd = 0;
         rx_done_m = 1'b0;
         tx_mark_m = 1'b0;
         rx_en_m   = 1'b0;
         sbuf_rsp_q.delete();
      end else begin
         // response of the previous request first, then this edge's request
         if (rsp_valid) begin
            got = {rsp_data_out, rsp_data_valid, rsp_rx_flag, rsp_tx_busy, rsp_dropped};
            if (sbuf_rsp_q.size() == 0) begin
               $display("%0t: response with none expected, actual %0h", $time, got);
               fail_count++;
            end else begin
               want = sbuf_rsp_q.pop_front();
               check_field("data_out", want.data_out, got.data_out);
               check_field("data_valid", want.data_valid, got.data_valid);
               check_field("rx_flag", want.rx_flag, got.rx_flag);
               check_field("tx_busy", want.tx_busy, got.tx_busy);
               check_field("dropped", want.dropped, got.dropped);
            end
         end
         if (start && !busy)
            sbuf_rsp_q.push_back(predict_sbuf(action_type'(req_action), req_data_in));
         if (csr_wr_en)
            rx_en_m = csr_wr_data;
      end
      pending = sbuf_rsp_q.size();
   end

endmodule

### test/uart_sbuf_dual_fifo_tb.sv
`timescale 1ns / 1ps
// Top of the uart_sbuf_dual_fifo bench: clock, reset, request stimulus and
// the verdict. Depends on usbf_pkg, uart_sbuf_dual_fifo and uart_sbuf_dual_fifo_checker.
module uart_sbuf_dual_fifo_tb;
   import usbf_pkg::*;

   localparam int NUM_PHASES = 6;
   localparam int PHASE_REQS = 192;   // requests per random phase

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [1:0] req_action = ACT_CPU_WRITE;
   logic [7:0] req_data_in = 8'h00;
   logic       rsp_valid;
   logic [7:0] rsp_data_out;
   logic       rsp_data_valid;
   logic       rsp_rx_flag;
   logic       rsp_tx_busy;
   logic       rsp_dropped;
   logic       csr_wr_en = 1'b0;
   logic       csr_wr_data = 1'b0;
   int         fail_count;
   int         pending;

   // per-phase plan: sender idle percentage and receiver enable
   int   idle_plan  [NUM_PHASES] = '{0, 71, 21, 0, 71, 21};
   logic rx_en_plan [NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};

   int   counted;           // requests sent this phase
   int   idle_pct;

   uart_sbuf_dual_fifo u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_data_in    (req_data_in),
      .rsp_valid      (rsp_valid),
      .rsp_data_out   (rsp_data_out),
      .rsp_data_valid (rsp_data_valid),
      .rsp_rx_flag    (rsp_rx_flag),
      .rsp_tx_busy    (rsp_tx_busy),
      .rsp_dropped    (rsp_dropped),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   uart_sbuf_dual_fifo_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_data_in    (req_data_in),
      .rsp_valid      (rsp_valid),
      .rsp_data_out   (rsp_data_out),
      .rsp_data_valid (rsp_data_valid),
      .rsp_rx_flag    (rsp_rx_flag),
      .rsp_tx_busy    (rsp_tx_busy),
      .rsp_dropped    (rsp_dropped),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .fail_count     (fail_count),
      .pending        (pending)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Safety net: the slowest legal run is far below this.
   initial begin
      #5_000_000;
      $display("uart_sbuf_dual_fifo: mismatch");
      $finish;
   end

   // Data bytes lean on the extremes now and then; otherwise uniform.
   function automatic logic [7:0] pick_data();
      case ($urandom_range(0, 9))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // One idle cycle: start low, request lines carry noise.
   task automatic idle_cycle();
      @(negedge clock);
      start       <= 1'b0;
      req_action  <= 2'($urandom_range(0, 3));
      req_data_in <= 8'($urandom_range(0, 255));
   endtask

   // Drop start and wait until every outstanding response has been seen.
   task automatic drain_responses();
      idle_cycle();
      while (pending != 0)
         @(posedge clock);
   endtask

   // Present one request and hold it until accepted. busy read right after
   // the edge is still the value the edge itself sampled. start stays high
   // on return so back-to-back requests need no extra assignment.
   task automatic send_request(action_type act, logic [7:0] din);
      int gaps;
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         gaps = $urandom_range(1, 4);
         repeat (gaps) idle_cycle();
      end
      @(negedge clock);
      start       <= 1'b1;
      req_action  <= act;
      req_data_in <= din;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      counted++;
   endtask

   // rx_enable may only change with nothing in flight; all responses are drained
   // and a margin is waited before the write.
   task automatic set_rx_enable(logic value);
      drain_responses();
      repeat (2) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      int   kind;
      int   len;
      logic [7:0] din;

      // reset: held from the start, released away from the active edge
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      idle_pct = 0;
      set_rx_enable(1'b0);
      send_request(ACT_CPU_READ, 8'h00);   // receive ring empty
      send_request(ACT_LINE_TX, 8'h00);    // transmit ring empty
      send_request(ACT_LINE_RX, 8'hFF);    // receiver off: ignored
      send_request(ACT_CPU_WRITE, 8'h00);
      send_request(ACT_CPU_WRITE, 8'hFF);
      send_request(ACT_CPU_WRITE, 8'h5A);
      send_request(ACT_LINE_TX, 8'hFF);
      send_request(ACT_LINE_TX, 8'h00);
      send_request(ACT_LINE_TX, 8'hA5);
      send_request(ACT_LINE_TX, 8'h00);    // empty again; tx busy mark stays
      set_rx_enable(1'b1);
      send_request(ACT_LINE_RX, 8'h00);
      send_request(ACT_LINE_RX, 8'hFF);
      send_request(ACT_LINE_RX, 8'hA5);
      send_request(ACT_CPU_READ, 8'hFF);
      send_request(ACT_CPU_READ, 8'h00);
      send_request(ACT_CPU_READ, 8'h55);
      send_request(ACT_CPU_READ, 8'h00);   // empty read, rx flag stays sticky

      // ---- random part ----
      // Bursts of one kind walk the rings to full and back to empty, so the
      // drop cases and pointer wrap come up often; mixed bursts add noise.
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         set_rx_enable(rx_en_plan[ph]);
         idle_pct = idle_plan[ph];
         counted  = 0;
         while (counted < PHASE_REQS) begin
            // occasional full stop until all responses are back
            if ($urandom_range(0, 39) == 0)
               drain_responses();
            kind = $urandom_range(0, 5);
            len  = $urandom_range(1, 24);
            for (int k = 0; k < len && counted < PHASE_REQS; k++) begin
               din = pick_data();
               case (kind)
                  0:       send_request(ACT_CPU_WRITE, din);
                  1:       send_request(ACT_LINE_TX, din);
                  2:       send_request(ACT_LINE_RX, din);
                  3:       send_request(ACT_CPU_READ, din);
                  default: send_request(action_type'($urandom_range(0, 3)), din);
               endcase
            end
         end
      end

      // ---- wind down ----
      drain_responses();
      repeat (4) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("uart_sbuf_dual_fifo: match");
      end else begin
         $display("uart_sbuf_dual_fifo: mismatch");
      end
      $finish;
   end

endmodule
